### src/rvx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RV32I execute unit.
// Depends on nothing; used by every module of the unit.
package rvx_pkg;

	// Operation codes, base instruction file order
	localparam logic [5:0] OP_LUI    = 6'd0;
	localparam logic [5:0] OP_AUIPC  = 6'd1;
	localparam logic [5:0] OP_JAL    = 6'd2;
	localparam logic [5:0] OP_JALR   = 6'd3;
	localparam logic [5:0] OP_BEQ    = 6'd4;
	localparam logic [5:0] OP_BNE    = 6'd5;
	localparam logic [5:0] OP_BLT    = 6'd6;
	localparam logic [5:0] OP_BGE    = 6'd7;
	localparam logic [5:0] OP_BLTU   = 6'd8;
	localparam logic [5:0] OP_BGEU   = 6'd9;
	localparam logic [5:0] OP_LB     = 6'd10;
	localparam logic [5:0] OP_LH     = 6'd11;
	localparam logic [5:0] OP_LW     = 6'd12;
	localparam logic [5:0] OP_LBU    = 6'd13;
	localparam logic [5:0] OP_LHU    = 6'd14;
	localparam logic [5:0] OP_SB     = 6'd15;
	localparam logic [5:0] OP_SH     = 6'd16;
	localparam logic [5:0] OP_SW     = 6'd17;
	localparam logic [5:0] OP_ADDI   = 6'd18;
	localparam logic [5:0] OP_SLTI   = 6'd19;
	localparam logic [5:0] OP_SLTIU  = 6'd20;
	localparam logic [5:0] OP_XORI   = 6'd21;
	localparam logic [5:0] OP_ORI    = 6'd22;
	localparam logic [5:0] OP_ANDI   = 6'd23;
	localparam logic [5:0] OP_SLLI   = 6'd24;
	localparam logic [5:0] OP_SRLI   = 6'd25;
	localparam logic [5:0] OP_SRAI   = 6'd26;
	localparam logic [5:0] OP_ADD    = 6'd27;
	localparam logic [5:0] OP_SUB    = 6'd28;
	localparam logic [5:0] OP_SLL    = 6'd29;
	localparam logic [5:0] OP_SLT    = 6'd30;
	localparam logic [5:0] OP_SLTU   = 6'd31;
	localparam logic [5:0] OP_XOR    = 6'd32;
	localparam logic [5:0] OP_SRL    = 6'd33;
	localparam logic [5:0] OP_SRA    = 6'd34;
	localparam logic [5:0] OP_OR     = 6'd35;
	localparam logic [5:0] OP_AND    = 6'd36;
	localparam logic [5:0] OP_FENCE  = 6'd37;
	localparam logic [5:0] OP_ECALL  = 6'd38;
	localparam logic [5:0] OP_CSRRW  = 6'd39;
	localparam logic [5:0] OP_CSRRS  = 6'd40;
	localparam logic [5:0] OP_CSRRC  = 6'd41;
	localparam logic [5:0] OP_CSRRWI = 6'd42;
	localparam logic [5:0] OP_CSRRSI = 6'd43;
	localparam logic [5:0] OP_CSRRCI = 6'd44;
	localparam logic [5:0] OP_MRET   = 6'd45;

	// Memory request kinds
	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_READ  = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	// Access sizes in bytes
	localparam logic [2:0] SIZE_NONE = 3'd0;
	localparam logic [2:0] SIZE_BYTE = 3'd1;
	localparam logic [2:0] SIZE_HALF = 3'd2;
	localparam logic [2:0] SIZE_WORD = 3'd4;

	localparam int          UPPER_SHIFT = 12;
	localparam logic [31:0] JALR_MASK   = 32'hFFFF_FFFE;
	localparam logic [31:0] STEP_SHORT  = 32'd2;
	localparam logic [31:0] STEP_FULL   = 32'd4;

	typedef enum logic [3:0] {
		ALU_NONE,
		ALU_ADD,
		ALU_SUB,
		ALU_SLL,
		ALU_SLT,
		ALU_SLTU,
		ALU_XOR,
		ALU_SRL,
		ALU_SRA,
		ALU_OR,
		ALU_AND,
		ALU_LUI,
		ALU_AUIPC,
		ALU_LINK,
		ALU_CSR
	} alu_t;

	typedef enum logic [3:0] {
		NXT_STEP,
		NXT_JAL,
		NXT_JALR,
		NXT_MRET,
		NXT_BEQ,
		NXT_BNE,
		NXT_BLT,
		NXT_BGE,
		NXT_BLTU,
		NXT_BGEU
	} nxt_t;

	typedef enum logic [1:0] {
		CSR_NONE,
		CSR_WRITE,
		CSR_SET,
		CSR_CLEAR
	} csr_t;

	typedef struct packed {
		logic [5:0]         req_type;
		logic [31:0]        pc;
		logic [31:0]        src_a;
		logic [31:0]        src_b;
		logic signed [31:0] imm;
		logic [31:0]        csr_old;
		logic               src_is_zero;
		logic [4:0]         dest_index;
		logic               short_form;
	} req_t;

	typedef struct packed {
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic [31:0] next_pc;
		logic [1:0]  mem_kind;
		logic [31:0] mem_address;
		logic [2:0]  mem_bytes;
		logic        mem_signed;
		logic [31:0] store_value;
		logic        csr_write;
		logic [31:0] csr_new;
		logic        halt;
	} rsp_t;

	// Decoded controls that travel down the pipe
	typedef struct packed {
		alu_t       alu;
		logic       use_imm;
		logic       wr;
		logic [1:0] mem_kind;
		logic [2:0] mem_bytes;
		logic       mem_signed;
		nxt_t       nxt;
		csr_t       csr;
		logic       csr_imm;
		logic       halt;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctrl;
		req_t  req;
	} s1_t;

	typedef struct packed {
		ctrl_t       ctrl;
		logic [31:0] value;
		logic [31:0] pc_step;
		logic [31:0] pc_imm;
		logic [31:0] eff_addr;
		logic [31:0] src_b;
		logic [31:0] csr_old;
		logic [31:0] csr_src;
		logic        eq;
		logic        lt;
		logic        ltu;
		logic        src_is_zero;
		logic [4:0]  dest_index;
	} s2_t;

endpackage

### src/rvx_decode.sv
`timescale 1ns / 1ps
// Stage 1 of the execute unit: decode the operation code into controls.
// Depends on rvx_pkg.
module rvx_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  rvx_pkg::req_t req,
	output logic          valid_s1,
	output rvx_pkg::s1_t  item_s1
);
	import rvx_pkg::*;

	ctrl_t ctrl;

	always_comb begin
		ctrl            = '0;
		ctrl.alu        = ALU_NONE;
		ctrl.nxt        = NXT_STEP;
		ctrl.csr        = CSR_NONE;
		ctrl.mem_kind   = MEM_NONE;
		ctrl.mem_bytes  = SIZE_NONE;
		unique case (req.req_type)
			OP_LUI:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_LUI; end
			OP_AUIPC:  begin ctrl.wr = 1'b1; ctrl.alu = ALU_AUIPC; end
			OP_JAL:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_LINK; ctrl.nxt = NXT_JAL; end
			OP_JALR:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_LINK; ctrl.nxt = NXT_JALR; end
			OP_BEQ:    ctrl.nxt = NXT_BEQ;
			OP_BNE:    ctrl.nxt = NXT_BNE;
			OP_BLT:    ctrl.nxt = NXT_BLT;
			OP_BGE:    ctrl.nxt = NXT_BGE;
			OP_BLTU:   ctrl.nxt = NXT_BLTU;
			OP_BGEU:   ctrl.nxt = NXT_BGEU;
			OP_LB: begin
				ctrl.mem_kind = MEM_READ; ctrl.mem_bytes = SIZE_BYTE; ctrl.mem_signed = 1'b1;
			end
			OP_LH: begin
				ctrl.mem_kind = MEM_READ; ctrl.mem_bytes = SIZE_HALF; ctrl.mem_signed = 1'b1;
			end
			OP_LW:     begin ctrl.mem_kind = MEM_READ; ctrl.mem_bytes = SIZE_WORD; end
			OP_LBU:    begin ctrl.mem_kind = MEM_READ; ctrl.mem_bytes = SIZE_BYTE; end
			OP_LHU:    begin ctrl.mem_kind = MEM_READ; ctrl.mem_bytes = SIZE_HALF; end
			OP_SB:     begin ctrl.mem_kind = MEM_WRITE; ctrl.mem_bytes = SIZE_BYTE; end
			OP_SH:     begin ctrl.mem_kind = MEM_WRITE; ctrl.mem_bytes = SIZE_HALF; end
			OP_SW:     begin ctrl.mem_kind = MEM_WRITE; ctrl.mem_bytes = SIZE_WORD; end
			OP_ADDI:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_ADD;  ctrl.use_imm = 1'b1; end
			OP_SLTI:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_SLT;  ctrl.use_imm = 1'b1; end
			OP_SLTIU:  begin ctrl.wr = 1'b1; ctrl.alu = ALU_SLTU; ctrl.use_imm = 1'b1; end
			OP_XORI:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_XOR;  ctrl.use_imm = 1'b1; end
			OP_ORI:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_OR;   ctrl.use_imm = 1'b1; end
			OP_ANDI:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_AND;  ctrl.use_imm = 1'b1; end
			OP_SLLI:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_SLL;  ctrl.use_imm = 1'b1; end
			OP_SRLI:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_SRL;  ctrl.use_imm = 1'b1; end
			OP_SRAI:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_SRA;  ctrl.use_imm = 1'b1; end
			OP_ADD:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_ADD; end
			OP_SUB:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_SUB; end
			OP_SLL:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_SLL; end
			OP_SLT:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_SLT; end
			OP_SLTU:   begin ctrl.wr = 1'b1; ctrl.alu = ALU_SLTU; end
			OP_XOR:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_XOR; end
			OP_SRL:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_SRL; end
			OP_SRA:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_SRA; end
			OP_OR:     begin ctrl.wr = 1'b1; ctrl.alu = ALU_OR; end
			OP_AND:    begin ctrl.wr = 1'b1; ctrl.alu = ALU_AND; end
			OP_ECALL:  ctrl.halt = 1'b1;
			OP_CSRRW:  begin ctrl.wr = 1'b1; ctrl.alu = ALU_CSR; ctrl.csr = CSR_WRITE; end
			OP_CSRRS:  begin ctrl.wr = 1'b1; ctrl.alu = ALU_CSR; ctrl.csr = CSR_SET; end
			OP_CSRRC:  begin ctrl.wr = 1'b1; ctrl.alu = ALU_CSR; ctrl.csr = CSR_CLEAR; end
			OP_CSRRWI: begin
				ctrl.wr = 1'b1; ctrl.alu = ALU_CSR; ctrl.csr = CSR_WRITE; ctrl.csr_imm = 1'b1;
			end
			OP_CSRRSI: begin
				ctrl.wr = 1'b1; ctrl.alu = ALU_CSR; ctrl.csr = CSR_SET; ctrl.csr_imm = 1'b1;
			end
			OP_CSRRCI: begin
				ctrl.wr = 1'b1; ctrl.alu = ALU_CSR; ctrl.csr = CSR_CLEAR; ctrl.csr_imm = 1'b1;
			end
			OP_MRET:   ctrl.nxt = NXT_MRET;
			// FENCE and unused codes fall through as no-ops
			default:   ;
		endcase
		// x0 is never written
		if (req.dest_index == 5'd0) begin
			ctrl.wr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.ctrl <= ctrl;
			item_s1.req  <= req;
		end
	end

endmodule

### src/rvx_alu.sv
`timescale 1ns / 1ps
// Stage 2 of the execute unit: ALU, compares and the address adders.
// Depends on rvx_pkg.
module rvx_alu (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	input  rvx_pkg::s1_t item_s1,
	output logic         valid_s2,
	output rvx_pkg::s2_t item_s2
);
	import rvx_pkg::*;

	logic [31:0] src_a;
	logic [31:0] imm;
	logic [31:0] opb;
	logic [4:0]  shamt;
	logic [31:0] pc_step;
	logic        lt;
	logic        ltu;
	logic [31:0] value;

	assign src_a   = item_s1.req.src_a;
	assign imm     = $unsigned(item_s1.req.imm);
	assign opb     = item_s1.ctrl.use_imm ? imm : item_s1.req.src_b;
	assign shamt   = opb[4:0];
	assign pc_step = item_s1.req.pc + (item_s1.req.short_form ? STEP_SHORT : STEP_FULL);
	assign lt      = $signed(src_a) < $signed(opb);
	assign ltu     = src_a < opb;

	always_comb begin
		case (item_s1.ctrl.alu)
			ALU_ADD:   value = src_a + opb;
			ALU_SUB:   value = src_a - opb;
			ALU_SLL:   value = src_a << shamt;
			ALU_SLT:   value = {31'd0, lt};
			ALU_SLTU:  value = {31'd0, ltu};
			ALU_XOR:   value = src_a ^ opb;
			ALU_SRL:   value = src_a >> shamt;
			ALU_SRA:   value = $unsigned($signed(src_a) >>> shamt);
			ALU_OR:    value = src_a | opb;
			ALU_AND:   value = src_a & opb;
			ALU_LUI:   value = imm << UPPER_SHIFT;
			ALU_AUIPC: value = item_s1.req.pc + (imm << UPPER_SHIFT);
			ALU_LINK:  value = pc_step;
			ALU_CSR:   value = item_s1.req.csr_old;
			default:   value = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			item_s2.ctrl        <= item_s1.ctrl;
			item_s2.value       <= value;
			item_s2.pc_step     <= pc_step;
			item_s2.pc_imm      <= item_s1.req.pc + imm;
			item_s2.eff_addr    <= src_a + imm;
			item_s2.src_b       <= item_s1.req.src_b;
			item_s2.csr_old     <= item_s1.req.csr_old;
			item_s2.csr_src     <= item_s1.ctrl.csr_imm ? imm : src_a;
			item_s2.eq          <= src_a == opb;
			item_s2.lt          <= lt;
			item_s2.ltu         <= ltu;
			item_s2.src_is_zero <= item_s1.req.src_is_zero;
			item_s2.dest_index  <= item_s1.req.dest_index;
		end
	end

endmodule

### src/rvx_commit.sv
`timescale 1ns / 1ps
// Stage 3 of the execute unit: branch resolve, next PC, memory and CSR results.
// Depends on rvx_pkg.
module rvx_commit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s2,
	input  rvx_pkg::s2_t  item_s2,
	output logic          done_s3,
	output rvx_pkg::rsp_t rsp_s3
);
	import rvx_pkg::*;

	logic        take;
	logic [31:0] next_pc;
	logic        csr_wr;
	logic [31:0] csr_new;

	always_comb begin
		take    = 1'b0;
		next_pc = item_s2.pc_step;
		case (item_s2.ctrl.nxt)
			NXT_JAL:  next_pc = item_s2.pc_imm;
			NXT_JALR: next_pc = item_s2.eff_addr & JALR_MASK;
			NXT_MRET: next_pc = item_s2.csr_old;
			NXT_BEQ:  take = item_s2.eq;
			NXT_BNE:  take = !item_s2.eq;
			NXT_BLT:  take = item_s2.lt;
			NXT_BGE:  take = !item_s2.lt;
			NXT_BLTU: take = item_s2.ltu;
			NXT_BGEU: take = !item_s2.ltu;
			default:  ;
		endcase
		if (take) begin
			next_pc = item_s2.pc_imm;
		end
	end

	// Set and clear skip the write when the source is zero
	always_comb begin
		csr_wr  = 1'b0;
		csr_new = item_s2.csr_old;
		case (item_s2.ctrl.csr)
			CSR_WRITE: begin
				csr_wr  = 1'b1;
				csr_new = item_s2.csr_src;
			end
			CSR_SET: begin
				csr_wr = !item_s2.src_is_zero;
				if (csr_wr) begin
					csr_new = item_s2.csr_old | item_s2.csr_src;
				end
			end
			CSR_CLEAR: begin
				csr_wr = !item_s2.src_is_zero;
				if (csr_wr) begin
					csr_new = item_s2.csr_old & ~item_s2.csr_src;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			rsp_s3.reg_write   <= item_s2.ctrl.wr;
			rsp_s3.reg_index   <= item_s2.dest_index;
			rsp_s3.reg_value   <= item_s2.ctrl.wr ? item_s2.value : 32'd0;
			rsp_s3.next_pc     <= next_pc;
			rsp_s3.mem_kind    <= item_s2.ctrl.mem_kind;
			rsp_s3.mem_address <= (item_s2.ctrl.mem_kind != MEM_NONE) ? item_s2.eff_addr : 32'd0;
			rsp_s3.mem_bytes   <= item_s2.ctrl.mem_bytes;
			rsp_s3.mem_signed  <= item_s2.ctrl.mem_signed;
			rsp_s3.store_value <= (item_s2.ctrl.mem_kind == MEM_WRITE) ? item_s2.src_b : 32'd0;
			rsp_s3.csr_write   <= csr_wr;
			rsp_s3.csr_new     <= csr_new;
			rsp_s3.halt        <= item_s2.ctrl.halt;
		end
	end

endmodule

### src/rv32ic_execute_unit.sv
`timescale 1ns / 1ps
// RV32I execute unit, top level: decode, ALU and commit stages in a row.
// Depends on rvx_pkg, rvx_decode, rvx_alu and rvx_commit.
//
// Usage:
//   Drive one decoded instruction on req and raise start. The beat is taken
//   at the rising edge where start is high and busy is low. busy stays low:
//   the pipe never stalls, so a new instruction can be taken every cycle.
//   Each result appears on rsp for exactly one cycle with done high, after its
//   instruction has passed the decode, ALU and commit registers in that order.
//   Throughput is one instruction per cycle, set by the three register
//   stages that each take a new beat on every edge.
//   The receiver cannot hold results off; it must take rsp when done is high.
//   Results come out in the order the instructions went in.
//   Reset (arst_n low) clears the stage valid bits, dropping any beats in
//   flight; no result is shown until a new instruction is taken.
module rv32ic_execute_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rvx_pkg::req_t req,
	output logic          done,
	output rvx_pkg::rsp_t rsp
);
	import rvx_pkg::*;

	logic load;
	logic valid_s1;
	s1_t  item_s1;
	logic valid_s2;
	s2_t  item_s2;

	assign busy = 1'b0;
	assign load = start && !busy;

	rvx_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.req      (req),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rvx_alu u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2)
	);

	rvx_commit u_commit (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.done_s3  (done),
		.rsp_s3   (rsp)
	);

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ##3 done)
		else $error("accepted beat did not complete after three cycles");

	a_no_orphan : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(load, 3))
		else $error("result without an accepted beat");

	a_no_x0 : assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.reg_write |-> rsp.reg_index != 5'd0)
		else $error("write to x0");

	a_csr_hold : assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.csr_write |-> rsp.csr_new == $past(req.csr_old, 3))
		else $error("CSR value changed without a write");

	a_mem_idle : assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.mem_kind == MEM_NONE) |->
			(rsp.mem_bytes == SIZE_NONE) && (rsp.mem_address == 32'd0)
			&& (rsp.store_value == 32'd0))
		else $error("memory fields set without a request");

endmodule
